// File: rtl/ssd_pkg.sv
package ssd_pkg;

    localparam int FRAME_BITS_DEF = 24;
    localparam int RUN_BITS       = 24;
    localparam int CFG_BITS       = 16;
    localparam int CFG_ADDR_BITS  = 2;
    localparam int OUT_BITS       = 24;

    localparam logic [CFG_ADDR_BITS-1:0] CFG_SPEECH_THRESHOLD = 2'd0;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_MIN_SPEECH_LEN   = 2'd1;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_MIN_SILENCE_LEN  = 2'd2;

    localparam logic [CFG_BITS-1:0] SPEECH_THRESHOLD_RST = 16'd16384;
    localparam logic [CFG_BITS-1:0] MIN_SPEECH_LEN_RST   = 16'd25;
    localparam logic [CFG_BITS-1:0] MIN_SILENCE_LEN_RST  = 16'd20;

    typedef struct packed {
        logic [15:0] speech_prob;
        logic        last_frame;
    } t_in;

    typedef struct packed {
        logic [OUT_BITS-1:0] seg_start_frame;
        logic [OUT_BITS-1:0] seg_end_frame;
        logic                closed_by_end;
    } t_out;

    typedef struct packed {
        logic [CFG_BITS-1:0] speech_threshold;
        logic [CFG_BITS-1:0] min_speech_len;
        logic [CFG_BITS-1:0] min_silence_len;
    } t_cfg;

endpackage

// File: rtl/ssd_step.sv
module ssd_step #(
    parameter int FRAME_BITS = ssd_pkg::FRAME_BITS_DEF
) (
    input  ssd_pkg::t_in                  i_in,
    input  ssd_pkg::t_cfg                 i_cfg,
    input  logic                          i_in_speech,
    input  logic [ssd_pkg::RUN_BITS-1:0]  i_speech_run,
    input  logic [ssd_pkg::RUN_BITS-1:0]  i_silence_run,
    input  logic [FRAME_BITS-1:0]         i_open_start,
    input  logic [FRAME_BITS-1:0]         i_frame_index,
    output logic                          o_in_speech,
    output logic [ssd_pkg::RUN_BITS-1:0]  o_speech_run,
    output logic [ssd_pkg::RUN_BITS-1:0]  o_silence_run,
    output logic [FRAME_BITS-1:0]         o_open_start,
    output logic [FRAME_BITS-1:0]         o_frame_index,
    output logic                          o_valid,
    output ssd_pkg::t_out                 o_out
);
    import ssd_pkg::*;

    localparam int CMP_BITS = (FRAME_BITS > CFG_BITS) ? FRAME_BITS : CFG_BITS;
    localparam logic [RUN_BITS-1:0] RUN_MAX = {RUN_BITS{1'b1}};
    localparam logic [FRAME_BITS-1:0] ONE_F = {{(FRAME_BITS-1){1'b0}}, 1'b1};

    logic                  is_speech;
    logic [RUN_BITS-1:0]   sp_inc;
    logic [RUN_BITS-1:0]   si_inc;
    logic [FRAME_BITS-1:0] seg_end;
    logic [FRAME_BITS-1:0] seg_len;
    logic [FRAME_BITS-1:0] next_index;

    assign is_speech  = i_in.speech_prob >= i_cfg.speech_threshold;
    assign sp_inc     = (i_speech_run == RUN_MAX) ? i_speech_run : i_speech_run + 1'b1;
    assign si_inc     = (i_silence_run == RUN_MAX) ? i_silence_run : i_silence_run + 1'b1;
    assign seg_end    = i_frame_index - FRAME_BITS'(si_inc) + ONE_F;
    assign seg_len    = seg_end - i_open_start;
    assign next_index = i_frame_index + ONE_F;

    always_comb begin
        o_in_speech   = i_in_speech;
        o_speech_run  = i_speech_run;
        o_silence_run = i_silence_run;
        o_open_start  = i_open_start;
        o_frame_index = next_index;
        o_valid       = 1'b0;
        o_out         = '0;

        if (is_speech) begin
            o_speech_run  = sp_inc;
            o_silence_run = '0;
            if (!i_in_speech && (sp_inc >= RUN_BITS'(i_cfg.min_speech_len))) begin
                o_in_speech  = 1'b1;
                o_open_start = i_frame_index - FRAME_BITS'(sp_inc) + ONE_F;
            end
        end else begin
            o_silence_run = si_inc;
            o_speech_run  = '0;
            if (i_in_speech && (si_inc >= RUN_BITS'(i_cfg.min_silence_len))) begin
                o_in_speech = 1'b0;
                if (CMP_BITS'(seg_len) >= CMP_BITS'(i_cfg.min_speech_len)) begin
                    o_valid               = 1'b1;
                    o_out.seg_start_frame = OUT_BITS'(i_open_start);
                    o_out.seg_end_frame   = OUT_BITS'(seg_end);
                    o_out.closed_by_end   = 1'b0;
                end
            end
        end

        if (i_in.last_frame) begin
            // flush a segment still open at the end of the utterance
            if (o_in_speech) begin
                o_valid               = 1'b1;
                o_out.seg_start_frame = OUT_BITS'(o_open_start);
                o_out.seg_end_frame   = OUT_BITS'(next_index);
                o_out.closed_by_end   = 1'b1;
            end
            o_in_speech   = 1'b0;
            o_speech_run  = '0;
            o_silence_run = '0;
            o_open_start  = '0;
            o_frame_index = '0;
        end
    end

endmodule

// File: rtl/speech_segment_detector.sv
// Speech segment detector: takes one Q1.15 speech probability per frame and
// returns at most one segment (start frame, end frame, closed-by-end flag) per
// frame. Each frame beat lands in an input register and is resolved by a single
// compare / counter-update stage into the result register when that one is free,
// so the block sustains one frame per clock while the downstream side keeps taking
// results; the only stall is a full result register that the downstream side does
// not take. Registers are written through a plain write port; the user must write
// them only while the block is idle, as the block itself does not enforce this.
module speech_segment_detector #(
    parameter int FRAME_BITS = ssd_pkg::FRAME_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [ssd_pkg::CFG_ADDR_BITS-1:0]  i_cfg_addr,
    input  logic [ssd_pkg::CFG_BITS-1:0]       i_cfg_wdata,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  ssd_pkg::t_in                       i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output ssd_pkg::t_out                      o_out_data
);
    import ssd_pkg::*;

    t_cfg                  r_cfg;
    logic                  r_in_valid;
    t_in                   r_in;
    logic                  r_out_valid;
    t_out                  r_out;
    logic                  r_in_speech;
    logic [RUN_BITS-1:0]   r_speech_run;
    logic [RUN_BITS-1:0]   r_silence_run;
    logic [FRAME_BITS-1:0] r_open_start;
    logic [FRAME_BITS-1:0] r_frame_index;

    logic                  n_in_speech;
    logic [RUN_BITS-1:0]   n_speech_run;
    logic [RUN_BITS-1:0]   n_silence_run;
    logic [FRAME_BITS-1:0] n_open_start;
    logic [FRAME_BITS-1:0] n_frame_index;
    logic                  n_valid;
    t_out                  n_out;

    logic fire;

    assign fire        = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || fire;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    ssd_step #(
        .FRAME_BITS(FRAME_BITS)
    ) u_step (
        .i_in          (r_in),
        .i_cfg         (r_cfg),
        .i_in_speech   (r_in_speech),
        .i_speech_run  (r_speech_run),
        .i_silence_run (r_silence_run),
        .i_open_start  (r_open_start),
        .i_frame_index (r_frame_index),
        .o_in_speech   (n_in_speech),
        .o_speech_run  (n_speech_run),
        .o_silence_run (n_silence_run),
        .o_open_start  (n_open_start),
        .o_frame_index (n_frame_index),
        .o_valid       (n_valid),
        .o_out         (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.speech_threshold <= SPEECH_THRESHOLD_RST;
            r_cfg.min_speech_len   <= MIN_SPEECH_LEN_RST;
            r_cfg.min_silence_len  <= MIN_SILENCE_LEN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_SPEECH_THRESHOLD: r_cfg.speech_threshold <= i_cfg_wdata;
                CFG_MIN_SPEECH_LEN:   r_cfg.min_speech_len   <= i_cfg_wdata;
                CFG_MIN_SILENCE_LEN:  r_cfg.min_silence_len  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // input beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    // frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_speech   <= 1'b0;
            r_speech_run  <= '0;
            r_silence_run <= '0;
            r_open_start  <= '0;
            r_frame_index <= '0;
        end else if (fire) begin
            r_in_speech   <= n_in_speech;
            r_speech_run  <= n_speech_run;
            r_silence_run <= n_silence_run;
            r_open_start  <= n_open_start;
            r_frame_index <= n_frame_index;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= n_valid;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && n_valid) begin
            r_out <= n_out;
        end
    end

endmodule
